FILE: hdl/assert_macros.svh
// Assertion macros used by the floor texel mapper unit.
// Depends on nothing; the checks compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, a, c)
`define CHK_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: hdl/pftm_pkg.sv
// Package for the perspective floor texel mapper: payload types and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package pftm_pkg;
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int TEXTURE_MAX   = 1024;
    localparam int HORIZON       = SCREEN_HEIGHT / 2;
    localparam int CENTRE        = SCREEN_WIDTH / 2;
    localparam int ROW_MARGIN    = 40;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_CAMERA_X       = 3'd0,
        REG_CAMERA_HEIGHT  = 3'd1,
        REG_CAMERA_Z       = 3'd2,
        REG_COS_HEADING    = 3'd3,
        REG_SIN_HEADING    = 3'd4,
        REG_FOCAL_DISTANCE = 3'd5,
        REG_TEXTURE_WIDTH  = 3'd6,
        REG_TEXTURE_HEIGHT = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [7:0] screen_y;
        logic [8:0] screen_x;
    } pixel_t;

    typedef struct packed {
        logic [19:0] texel_address;
        logic [9:0]  texel_y;
        logic [9:0]  texel_x;
        logic        inside_res;
        logic        row_drawn;
    } texel_t;

    typedef struct packed {
        logic signed [23:0] camera_x;
        logic signed [23:0] camera_height;
        logic signed [23:0] camera_z;
        logic signed [15:0] cos_heading;
        logic signed [15:0] sin_heading;
        logic [19:0]        focal_distance;
        logic [10:0]        texture_width;
        logic [10:0]        texture_height;
    } config_t;
endpackage

FILE: hdl/pftm_divider.sv
// Pipelined signed floor divider: 64-bit numerator by a small positive divisor.
// One quotient bit per stage; depends on pftm_pkg.
`timescale 1ns / 1ps
module pftm_divider
    import pftm_pkg::*;
(
    input  logic               clk,
    input  logic signed [63:0] numerator,
    input  logic [6:0]         divisor,
    output logic signed [63:0] quotient
);
    // Divide magnitude bit by bit, carrying the remainder. The full 64-bit
    // quotient is built up through the stages, one bit per stage.
    localparam int NB = 64;
    logic [NB-1:0] num_reg  [0:NB];
    logic [NB-1:0] quo_reg  [0:NB];
    logic [7:0]    rem_reg  [0:NB];
    logic [6:0]    div_reg  [0:NB];
    logic          neg_reg  [0:NB];
    logic [NB-1:0] mag;

    assign mag = numerator[63] ? (~numerator + 64'd1) : numerator;

    always_ff @(posedge clk)
    begin
        num_reg[0] <= mag;
        quo_reg[0] <= '0;
        rem_reg[0] <= '0;
        div_reg[0] <= divisor;
        neg_reg[0] <= numerator[63];
    end

    genvar g;
    generate
        for (g = 0; g < NB; g++)
        begin : g_step
            logic [7:0] trial;
            logic       fits;
            assign trial = {rem_reg[g][6:0], num_reg[g][NB-1-g]};
            assign fits  = trial >= {1'b0, div_reg[g]};
            always_ff @(posedge clk)
            begin
                num_reg[g+1] <= num_reg[g];
                div_reg[g+1] <= div_reg[g];
                neg_reg[g+1] <= neg_reg[g];
                rem_reg[g+1] <= fits ? (trial - {1'b0, div_reg[g]}) : trial;
                quo_reg[g+1] <= {quo_reg[g][NB-2:0], fits};
            end
        end
    endgenerate

    // Floor for negatives: negate and subtract one when a remainder is left.
    always_comb
    begin
        if (neg_reg[NB])
            quotient = -$signed(quo_reg[NB]) - ((rem_reg[NB] != 8'd0) ? 64'sd1 : 64'sd0);
        else
            quotient = $signed(quo_reg[NB]);
    end
endmodule

FILE: hdl/perspective_floor_texel_mapper_unit.sv
// Usage: start/busy command channel, a strobed result channel and a write
// port for the eight registers (indexes as in reg_index_t).
// An item is taken at each edge with start high; busy is always low, so one
// pixel enters per clock and a result leaves per clock in input order.
// The first product register captures at the accepting edge; behind it sit
// a second product stage, the divider's input register and its 64 steps,
// the camera offset stage, the range check stage and the result register.
// Throughput: one item per cycle, set by the fully pipelined divider.
// The result appears on result with done high for exactly one cycle; the
// receiver cannot stall, so nothing is held back.
// Reset clears all valid bits and returns the registers to their defaults;
// no clearing pass is needed. Configuration must be written by the user only
// while the pipe is empty; the block itself does not enforce this.
// Depends on pftm_pkg, pftm_divider and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module perspective_floor_texel_mapper_unit
    import pftm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  pixel_t      pixel,
    output logic        done,
    output texel_t      result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    localparam int LAT = 69;
    config_t cfg_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_x       <= '0;
            cfg_reg.camera_height  <= '0;
            cfg_reg.camera_z       <= '0;
            cfg_reg.cos_heading    <= 16'sd16384;
            cfg_reg.sin_heading    <= '0;
            cfg_reg.focal_distance <= 20'd30720;
            cfg_reg.texture_width  <= 11'd1024;
            cfg_reg.texture_height <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_CAMERA_X:       cfg_reg.camera_x       <= cfg_data;
                REG_CAMERA_HEIGHT:  cfg_reg.camera_height  <= cfg_data;
                REG_CAMERA_Z:       cfg_reg.camera_z       <= cfg_data;
                REG_COS_HEADING:    cfg_reg.cos_heading    <= cfg_data[15:0];
                REG_SIN_HEADING:    cfg_reg.sin_heading    <= cfg_data[15:0];
                REG_FOCAL_DISTANCE: cfg_reg.focal_distance <= cfg_data[19:0];
                REG_TEXTURE_WIDTH:  cfg_reg.texture_width  <= cfg_data[10:0];
                REG_TEXTURE_HEIGHT: cfg_reg.texture_height <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Valid and drawn flags travel alongside the pipeline.
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] drw_reg;
    logic [9:0]     row_d;
    logic           drawn;
    assign drawn = (pixel.screen_x < 9'(SCREEN_WIDTH)) && (pixel.screen_y < 8'(SCREEN_HEIGHT))
                && ({2'b0, pixel.screen_y} >= 10'(HORIZON + ROW_MARGIN));
    assign row_d = {2'b0, pixel.screen_y} - 10'(HORIZON);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            drw_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start};
            drw_reg <= {drw_reg[LAT-2:0], start & drawn};
        end
    end

    // Stage 1: direction terms.
    logic signed [10:0] dx;
    logic signed [36:0] ax_reg, az_reg;
    logic [6:0]         d1_reg;
    assign dx = $signed({2'b0, pixel.screen_x}) - 11'(CENTRE);
    always_ff @(posedge clk)
    begin
        ax_reg <= 37'(dx * cfg_reg.cos_heading) * 37'sd256
                + 37'($signed({1'b0, cfg_reg.focal_distance}) * cfg_reg.sin_heading);
        az_reg <= 37'(dx * cfg_reg.sin_heading) * 37'sd256
                - 37'($signed({1'b0, cfg_reg.focal_distance}) * cfg_reg.cos_heading);
        d1_reg <= row_d[6:0];
    end

    // Stage 2: scale by camera height.
    logic signed [26:0] cy;
    logic signed [63:0] nx_reg, nz_reg;
    logic [6:0]         d2_reg;
    assign cy = 27'(cfg_reg.camera_height) * 27'sd6;
    always_ff @(posedge clk)
    begin
        nx_reg <= 64'(cy * ax_reg);
        nz_reg <= 64'(cy * az_reg);
        d2_reg <= (d1_reg == 7'd0) ? 7'd1 : d1_reg;
    end

    logic signed [63:0] qx, qz;
    pftm_divider u_div_x (.clk, .numerator(nx_reg), .divisor(d2_reg), .quotient(qx));
    pftm_divider u_div_z (.clk, .numerator(nz_reg), .divisor(d2_reg), .quotient(qz));

    // Stage A: add camera offsets, Q.8 positions aligned to 30 fraction bits.
    logic signed [63:0] xw_reg, zw_reg;
    logic signed [27:0] cx, cz;
    assign cx = -(28'(cfg_reg.camera_x) * 28'sd6);
    assign cz = 28'(cfg_reg.camera_z) * 28'sd6;
    always_ff @(posedge clk)
    begin
        xw_reg <= qx + (64'(cx) <<< 22);
        zw_reg <= qz + (64'(cz) <<< 22);
    end

    // Stage B: texture bounds.
    logic [10:0] w_sat, h_sat;
    logic        in_reg;
    logic [9:0]  tx_reg, ty_reg;
    logic [10:0] w_reg;
    assign w_sat = (cfg_reg.texture_width  > 11'(TEXTURE_MAX)) ? 11'(TEXTURE_MAX)
                                                              : cfg_reg.texture_width;
    assign h_sat = (cfg_reg.texture_height > 11'(TEXTURE_MAX)) ? 11'(TEXTURE_MAX)
                                                              : cfg_reg.texture_height;
    always_ff @(posedge clk)
    begin
        in_reg <= !xw_reg[63] && !zw_reg[63]
               && (xw_reg[62:30] < 33'(w_sat)) && (zw_reg[62:30] < 33'(h_sat));
        tx_reg <= xw_reg[39:30];
        ty_reg <= zw_reg[39:30];
        w_reg  <= w_sat;
    end

    // Stage C: address and output register.
    texel_t result_next;
    always_comb
    begin
        result_next = '0;
        if (drw_reg[LAT-1])
        begin
            result_next.row_drawn = 1'b1;
            if (in_reg)
            begin
                result_next.inside_res    = 1'b1;
                result_next.texel_x       = tx_reg;
                result_next.texel_y       = ty_reg;
                result_next.texel_address = 20'({10'd0, tx_reg} + ty_reg * w_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= vld_reg[LAT-1];
    end
    always_ff @(posedge clk)
    begin
        result <= result_next;
    end

    `CHK_IMPL(a_busy_low, clk, rst_n, 1'b1, !busy)
    `CHK_NEXT(a_done_follows, clk, rst_n, vld_reg[LAT-1], done)
    `CHK_IMPL(a_drawn_valid, clk, rst_n, drw_reg[LAT-1], vld_reg[LAT-1])
    `CHK_IMPL(a_inside_drawn, clk, rst_n, done && result.inside_res, result.row_drawn)
endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the perspective floor texel mapper unit.
// Depends on pftm_pkg and the unit's RTL; predicts each texel lookup in the bench itself.
`timescale 1ns / 1ps
module testbench;
    import pftm_pkg::*;

    localparam int LATENCY     = 69;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    pixel_t      pixel;
    logic        done;
    texel_t      result;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    perspective_floor_texel_mapper_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .pixel(pixel),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Bench copy of the register file.
    logic signed [23:0] cam_x, cam_h, cam_z;
    logic signed [15:0] cos_h, sin_h;
    logic [19:0]        focal;
    logic [10:0]        tex_w, tex_h;

    texel_t expected_texels[$];
    int     mismatches;
    int     cycle_count;
    bit     calm;

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Floored division that rounds toward minus infinity.
    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // Projects one screen pixel onto the floor texture.
    function automatic texel_t map_texel(pixel_t p);
        texel_t  t;
        longint  d, dx, cx, cy, cz, xw, zw, w, h, tx, ty;
        t = '0;
        w = (tex_w > TEXTURE_MAX) ? TEXTURE_MAX : tex_w;
        h = (tex_h > TEXTURE_MAX) ? TEXTURE_MAX : tex_h;
        if (p.screen_x >= SCREEN_WIDTH || p.screen_y >= SCREEN_HEIGHT
                || p.screen_y < HORIZON + ROW_MARGIN)
            return t;
        t.row_drawn = 1'b1;
        d  = longint'(p.screen_y) - HORIZON;
        dx = longint'(p.screen_x) - CENTRE;
        cx = -(longint'(cam_x) * 6);
        cy = longint'(cam_h) * 6;
        cz = longint'(cam_z) * 6;
        xw = cx * 4194304 + floor_quot(cy * (dx * longint'(cos_h) * 256
                + longint'(focal) * longint'(sin_h)), d);
        zw = cz * 4194304 + floor_quot(cy * (dx * longint'(sin_h) * 256
                - longint'(focal) * longint'(cos_h)), d);
        if (xw < 0 || zw < 0)
            return t;
        tx = xw >>> 30;
        ty = zw >>> 30;
        if (tx >= w || ty >= h)
            return t;
        t.inside_res    = 1'b1;
        t.texel_x       = tx[9:0];
        t.texel_y       = ty[9:0];
        t.texel_address = 20'(tx + ty * w);
        return t;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // Result checker: every strobed transaction against the oldest prediction.
    always @(posedge clk)
    begin
        texel_t want;
        if (rst_n && done)
        begin
            if (expected_texels.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = expected_texels.pop_front();
                if (result.row_drawn !== want.row_drawn)
                    report_mismatch("row_drawn", result.row_drawn, want.row_drawn);
                if (result.inside_res !== want.inside_res)
                    report_mismatch("inside_res", result.inside_res, want.inside_res);
                if (result.texel_x !== want.texel_x)
                    report_mismatch("texel_x", result.texel_x, want.texel_x);
                if (result.texel_y !== want.texel_y)
                    report_mismatch("texel_y", result.texel_y, want.texel_y);
                if (result.texel_address !== want.texel_address)
                    report_mismatch("texel_address", result.texel_address,
                                    want.texel_address);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("perspective_floor_texel_mapper_unit test failed");
            $finish;
        end
    end

    // Sends one pixel transaction, with an occasional random idle gap first.
    // Start stays high afterwards until the next idle cycle or a drain.
    task automatic send_pixel(logic [8:0] xs, logic [7:0] ys);
        pixel_t p;
        p.screen_x = xs;
        p.screen_y = ys;
        if (!calm)
        begin
            while ($urandom_range(99) < 13)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_texels.push_back(map_texel(p));
        @(negedge clk);
    endtask

    // Waits until all predictions are consumed, then lets the pipe drain.
    task automatic drain();
        start <= 1'b0;
        while (expected_texels.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Write enable stays high across a run of writes; the caller drops it.
    task automatic write_reg(reg_index_t idx, logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        case (idx)
            REG_CAMERA_X:       cam_x = value;
            REG_CAMERA_HEIGHT:  cam_h = value;
            REG_CAMERA_Z:       cam_z = value;
            REG_COS_HEADING:    cos_h = value[15:0];
            REG_SIN_HEADING:    sin_h = value[15:0];
            REG_FOCAL_DISTANCE: focal = value[19:0];
            REG_TEXTURE_WIDTH:  tex_w = value[10:0];
            REG_TEXTURE_HEIGHT: tex_h = value[10:0];
            default: ;
        endcase
    endtask

    // Drains the pipe, then writes all eight view registers.
    task automatic set_view(logic [23:0] cx, logic [23:0] ch, logic [23:0] cz,
                            logic [15:0] c, logic [15:0] s, logic [19:0] f,
                            logic [10:0] w, logic [10:0] h);
        drain();
        write_reg(REG_CAMERA_X, cx);
        write_reg(REG_CAMERA_HEIGHT, ch);
        write_reg(REG_CAMERA_Z, cz);
        write_reg(REG_COS_HEADING, {{8{c[15]}}, c});
        write_reg(REG_SIN_HEADING, {{8{s[15]}}, s});
        write_reg(REG_FOCAL_DISTANCE, {4'b0, f});
        write_reg(REG_TEXTURE_WIDTH, {13'b0, w});
        write_reg(REG_TEXTURE_HEIGHT, {13'b0, h});
        cfg_we <= 1'b0;
    endtask

    // Random floor-pixel coordinates, mostly on the drawn floor area.
    task automatic send_random_pixel();
        case ($urandom_range(9))
            0:       send_pixel(9'($urandom_range(511)), 8'($urandom_range(255)));
            1:       send_pixel(9'($urandom_range(319)), 8'($urandom_range(159)));
            default: send_pixel(9'($urandom_range(319)), 8'($urandom_range(239, 160)));
        endcase
    endtask

    // Directed extremes: screen corners, horizon margin, off-screen pixels and texture sizes.
    task automatic test_directed();
        send_pixel(9'd0, 8'd239);
        send_pixel(9'd319, 8'd239);
        send_pixel(9'd160, 8'd160);
        send_pixel(9'd160, 8'd159);
        send_pixel(9'd0, 8'd0);
        send_pixel(9'd320, 8'd200);
        send_pixel(9'd511, 8'd255);
        send_pixel(9'd100, 8'd240);
        set_view(24'd102400, -24'sd2560, -24'd170666, 16'd16384, 16'd0,
                 20'd30720, 11'd1024, 11'd1024);
        send_pixel(9'd160, 8'd239);
        send_pixel(9'd0, 8'd200);
        send_pixel(9'd319, 8'd160);
        send_pixel(9'd160, 8'd170);
        // Texture width zero and height oversize, saturated to the maximum.
        set_view(24'd102400, -24'sd2560, -24'd170666, 16'd16384, 16'd0,
                 20'd30720, 11'd0, 11'd2047);
        send_pixel(9'd160, 8'd239);
        send_pixel(9'd10, 8'd180);
    endtask

    // Random pixels under a series of camera settings, extremes included.
    task automatic test_random_views();
        for (int v = 0; v < 12; v++)
        begin
            case (v)
                0: set_view(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF,
                            20'hFFFFF, 11'd1, 11'd1);
                1: set_view(24'h800000, 24'h7FFFFF, 24'h800000, 16'h4000, 16'hC000,
                            20'd0, 11'd1024, 11'd1024);
                default: set_view(24'(-$urandom_range(200000, 10000)),
                                  24'(-$urandom_range(8000, 50)),
                                  24'($urandom_range(300000, 0) - 150000),
                                  16'($urandom_range(32768) - 16384),
                                  16'($urandom_range(32768) - 16384),
                                  20'($urandom_range(1048575)),
                                  11'($urandom_range(2047)), 11'($urandom_range(2047)));
            endcase
            calm = (v == 5);
            for (int i = 0; i < 150; i++)
                send_random_pixel();
            calm = 1'b0;
        end
    endtask

    // Sender holds off until the pipe is fully emptied, then resumes.
    task automatic test_pause_until_empty();
        for (int i = 0; i < 20; i++)
            send_random_pixel();
        drain();
        for (int i = 0; i < 20; i++)
            send_random_pixel();
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        pixel = '0;
        cfg_we = 1'b0;
        cfg_index = 3'd0;
        cfg_data = '0;
        mismatches = 0;
        cycle_count = 0;
        calm = 1'b0;
        cam_x = 0; cam_h = 0; cam_z = 0;
        cos_h = 16384; sin_h = 0; focal = 30720;
        tex_w = 1024; tex_h = 1024;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_pause_until_empty();
        test_random_views();
        drain();

        if (mismatches == 0)
            $display("perspective_floor_texel_mapper_unit test passed");
        else
            $display("perspective_floor_texel_mapper_unit test failed");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/pftm_pkg.sv
hdl/pftm_divider.sv
hdl/perspective_floor_texel_mapper_unit.sv
dv/testbench.sv
